@@ design/acrs_pkg.sv @@
// Package for the arc curve regime segmenter: sizes, fixed-point constants,
// register indexes and the divider control struct. No dependencies.
`default_nettype none
package acrs_pkg;
    localparam int MAX_LEN_DEF     = 1024;
    localparam int MAX_REGIMES_DEF = 16;
    localparam int NB_W            = 10;
    localparam int WIN_W           = 9;
    localparam int EZ_W            = 4;
    localparam int MR_W            = 5;
    localparam int VAL_W           = 17;
    localparam logic [VAL_W-1:0] ONE_Q16 = 17'h10000;
    localparam logic [1:0] REG_WINDOW = 2'd0;
    localparam logic [1:0] REG_EXCL   = 2'd1;
    localparam logic [1:0] REG_MAXREG = 2'd2;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_div_ctl;
endpackage
`default_nettype wire

@@ design/acrs_if.sv @@
// Valid/ready channel carrying a generic payload.
// Depends on nothing.
`default_nettype none
interface acrs_if #(parameter int W = 1) (input wire logic i_clk);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ design/acrs_div.sv @@
// Restoring divider, one quotient bit per cycle, quotient saturated at 1.0.
// Depends on acrs_pkg.
`default_nettype none
module acrs_div
    import acrs_pkg::*;
#(
    parameter int NW = 48,
    parameter int DW = 40
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_busy,
    output logic               o_done,
    output logic [VAL_W-1:0]   o_quo
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] r_q, n_q;
    logic [DW:0]   r_rem, n_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, r_done;
    logic [DW:0]   w_try;

    always_comb begin
        w_try = {r_rem[DW-1:0], r_q[NW-1]};
        n_q   = {r_q[NW-2:0], 1'b0};
        n_rem = w_try;
        if (w_try >= {1'b0, r_den}) begin
            n_rem = w_try - {1'b0, r_den};
            n_q[0] = 1'b1;
        end
        n_cnt = r_cnt - CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_q   <= n_q;
                r_rem <= n_rem;
                r_cnt <= n_cnt;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = (r_q > NW'(ONE_Q16)) ? ONE_Q16 : r_q[VAL_W-1:0];
endmodule
`default_nettype wire

@@ design/arc_curve_regime_segmenter_core.sv @@
// Top level of the arc curve regime segmenter. Uses acrs_pkg, acrs_if and
// the shared divider acrs_div.
`default_nettype none
// Load one nearest-neighbor entry per item; each passes through the accept,
// a read of the lower arc end, its write-back together with the read of the
// upper end, and the write-back of the upper end. After the entry marked
// last, the block walks the series once to build the corrected arc curve,
// waiting on the 39-step bit-serial divider at every position but position 0,
// clearing the arc store as it goes, then clears the rest of the store.
// Each minimum search reads the whole curve; each boundary then marks its
// exclusion zone, and a closing step ends the run. After reset a clearing
// pass zeroes the arc store while the input is held not ready. Results leave
// through a one-entry output register; a boundary is held until the next
// search shows whether it is the last one, and a stalled output holds the
// sequencer.
module arc_curve_regime_segmenter_core
    import acrs_pkg::*;
#(
    parameter int MAX_LEN     = MAX_LEN_DEF,
    parameter int MAX_REGIMES = MAX_REGIMES_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_we,
    input  wire logic [1:0] i_cfg_idx,
    input  wire logic [WIN_W-1:0] i_cfg_data,
    acrs_if.sink   i_in,
    acrs_if.source o_out
);
    localparam int AW  = $clog2(MAX_LEN);
    localparam int LW  = AW + 1;
    localparam int RW  = $clog2(MAX_REGIMES + 1);
    localparam int DTW = 12;
    localparam int SW  = LW + 2;
    localparam int NW  = LW + 1 + 16 + LW;
    localparam int DW  = 2 * LW + 1;
    localparam int ZW  = WIN_W + EZ_W;
    localparam int PW  = 2 * LW + 2;

    localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_LO = 4'd2, S_HI = 4'd3,
        S_BRD = 4'd4, S_BDIV = 4'd5, S_BWAIT = 4'd6, S_SRD = 4'd7, S_SCAN = 4'd8,
        S_EXCL = 4'd9, S_EMIT = 4'd10, S_FIN = 4'd11, S_BNEXT = 4'd12,
        S_HWR = 4'd13, S_CTAIL = 4'd14;

    logic [3:0] r_st;
    logic [WIN_W-1:0] r_win;
    logic [EZ_W-1:0]  r_ez;
    logic [MR_W-1:0]  r_mr;

    logic signed [DTW-1:0] r_arc [MAX_LEN];
    logic [VAL_W-1:0]      r_cv  [MAX_LEN];
    logic signed [DTW-1:0] r_arc_q;
    logic [VAL_W-1:0]      r_cv_q;

    logic [LW-1:0] r_len, r_i, r_idx;
    logic [AW-1:0] r_lo, r_hi;
    logic          r_lo_ok, r_hi_ok, r_last;
    logic signed [SW-1:0] r_run;
    logic [VAL_W-1:0] r_best;
    logic [RW-1:0] r_found;
    logic [LW-1:0] r_ex_end;
    logic [NB_W+1:0] r_out;
    logic r_ov;
    logic [NB_W-1:0] r_pend;
    logic r_pend_v;

    // divider
    logic          w_dstart, w_dbusy, w_ddone;
    logic [NW-1:0] w_num;
    logic [DW-1:0] w_den;
    logic [VAL_W-1:0] w_quo;
    logic [LW+1:0] w_cc;
    logic [PW-1:0] w_ccl;
    t_div_ctl w_dctl;

    acrs_div #(.NW(NW), .DW(DW)) u_div (
        .i_clk, .i_rst_n, .i_start(w_dstart), .i_num(w_num), .i_den(w_den),
        .o_busy(w_dbusy), .o_done(w_ddone), .o_quo(w_quo)
    );
    assign w_dctl = '{start: w_dstart, busy: w_dbusy, done: w_ddone};

    logic signed [SW-1:0] w_run_n;
    assign w_run_n = r_run + SW'(r_arc_q);
    assign w_cc    = w_run_n > 0 ? w_run_n[LW+1:0] : '0;
    assign w_ccl   = PW'(w_cc) * PW'(r_len);
    assign w_num   = NW'({w_ccl, 16'h0});
    assign w_den   = DW'({r_i, 1'b0}) * DW'(r_len - r_i);
    assign w_dstart = (r_st == S_BDIV) && (r_i != '0);

    logic [RW-1:0] w_limit;
    assign w_limit = (r_mr == '0 || 32'(r_mr) > MAX_REGIMES) ? RW'(MAX_REGIMES) : RW'(r_mr);
    logic [ZW-1:0] w_zone;
    assign w_zone = ZW'(r_win) * ZW'(r_ez);

    logic w_mask;
    assign w_mask = (32'(r_i) <= 32'(r_win)) ||
                    (32'(r_i) + 32'(r_win) + 1 >= 32'(r_len));

    // output register has room when empty or drained this cycle
    logic w_oroom, w_oload;
    assign w_oroom = !r_ov || o_out.ready;
    assign w_oload = w_oroom && ((r_st == S_EMIT && r_pend_v) || r_st == S_FIN);

    assign i_in.ready  = (r_st == S_IDLE);
    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

    logic [AW-1:0] w_p;
    logic [NB_W-1:0] w_nb;
    assign w_p  = r_len[AW-1:0];
    assign w_nb = i_in.data[NB_W:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= WIN_W'(16);
            r_ez  <= EZ_W'(5);
            r_mr  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WINDOW: r_win <= i_cfg_data;
                REG_EXCL:   r_ez  <= i_cfg_data[EZ_W-1:0];
                REG_MAXREG: r_mr  <= i_cfg_data[MR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR; r_i <= '0; r_len <= '0; r_ov <= 1'b0; r_pend_v <= 1'b0;
        end else begin
            r_ov <= w_oload ? 1'b1 : (o_out.ready ? 1'b0 : r_ov);
            unique case (r_st)
                S_CLR: begin
                    r_arc[r_i[AW-1:0]] <= '0;
                    r_i <= r_i + 1'b1;
                    if (32'(r_i) == MAX_LEN - 1) r_st <= S_IDLE;
                end
                S_IDLE: if (i_in.valid) begin
                    r_last <= i_in.data[0];
                    if (32'(r_len) < MAX_LEN) begin
                        r_lo <= (32'(w_p) < 32'(w_nb)) ? w_p : AW'(w_nb);
                        r_hi <= (32'(w_p) < 32'(w_nb)) ? AW'(w_nb) : w_p;
                        // the lower end is always inside the store
                        r_lo_ok <= 1'b1;
                        r_hi_ok <= 32'(w_nb) < MAX_LEN;
                        r_len <= r_len + 1'b1;
                    end else begin
                        // series too long: drop the entry
                        r_lo_ok <= 1'b0;
                        r_hi_ok <= 1'b0;
                    end
                    r_st <= S_LO;
                end
                S_LO: begin
                    r_arc_q <= r_arc[r_lo];
                    r_st <= S_HI;
                end
                S_HI: begin
                    if (r_lo_ok) r_arc[r_lo] <= r_arc_q + DTW'(1);
                    // self arc: forward the incremented value so the pair cancels
                    r_arc_q <= (r_hi == r_lo && r_lo_ok) ? r_arc_q + DTW'(1) : r_arc[r_hi];
                    r_st <= S_HWR;
                end
                S_HWR: begin
                    if (r_hi_ok) r_arc[r_hi] <= r_arc_q - DTW'(1);
                    r_i <= '0; r_run <= '0;
                    r_st <= r_last ? S_BRD : S_IDLE;
                end
                S_BRD: begin
                    r_arc_q <= r_arc[r_i[AW-1:0]];
                    r_st <= S_BDIV;
                end
                S_BDIV: begin
                    r_arc[r_i[AW-1:0]] <= '0;
                    r_st <= (r_i == '0) ? S_BNEXT : S_BWAIT;
                    if (r_i == '0) r_cv_q <= ONE_Q16;
                    r_run <= w_run_n;
                end
                S_BWAIT: if (w_dctl.done) begin
                    r_cv_q <= w_quo;
                    r_st <= S_BNEXT;
                end
                S_BNEXT: begin
                    r_cv[r_i[AW-1:0]] <= w_mask ? ONE_Q16 : r_cv_q;
                    r_i <= r_i + 1'b1;
                    if (r_i + 1'b1 == r_len) r_st <= S_CTAIL;
                    else r_st <= S_BRD;
                end
                S_CTAIL: begin
                    // clear arc ends that fell beyond the series
                    if (32'(r_i) < MAX_LEN) begin
                        r_arc[r_i[AW-1:0]] <= '0;
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_found <= '0;
                        r_st <= S_SRD;
                    end
                end
                S_SRD: begin
                    r_i <= '0; r_best <= ONE_Q16; r_idx <= '0;
                    r_st <= S_SCAN;
                end
                S_SCAN: begin
                    // one read per cycle; compare data of the previous address
                    if (r_i != '0 && r_cv_q < r_best) begin
                        r_best <= r_cv_q; r_idx <= r_i - 1'b1;
                    end
                    if (r_i != r_len) r_cv_q <= r_cv[r_i[AW-1:0]];
                    r_i <= r_i + 1'b1;
                    if (r_i == r_len) begin
                        if (r_best >= ONE_Q16 &&
                            !(r_i != '0 && r_cv_q < r_best)) r_st <= S_FIN;
                        else r_st <= S_EMIT;
                    end
                end
                S_EMIT: if (!r_pend_v || w_oroom) begin
                    // release the held boundary, hold the new one
                    if (r_pend_v) r_out <= {r_pend, 1'b0, 1'b0};
                    r_pend <= NB_W'(r_idx);
                    r_pend_v <= 1'b1;
                    r_found <= r_found + 1'b1;
                    r_i <= (32'(r_idx) > 32'(w_zone)) ? r_idx - LW'(w_zone) : '0;
                    r_ex_end <= (32'(r_idx) + 32'(w_zone) < 32'(r_len)) ?
                                r_idx + LW'(w_zone) : r_len;
                    r_st <= S_EXCL;
                end
                S_EXCL: begin
                    if (r_i < r_ex_end) begin
                        r_cv[r_i[AW-1:0]] <= ONE_Q16;
                        r_i <= r_i + 1'b1;
                    end else r_st <= (r_found == w_limit) ? S_FIN : S_SRD;
                end
                S_FIN: if (w_oroom) begin
                    // close the run: flag last on the held boundary or emit none_found
                    r_out <= r_pend_v ? {r_pend, 1'b0, 1'b1} : {NB_W'(0), 1'b1, 1'b1};
                    r_pend_v <= 1'b0;
                    r_len <= '0;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
